FILE: design/sjn_pkg.sv
// shared types, sizes and codes of the shortest-job-next queue
package sjn_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] TIME_STEP_RESET = 8'd20;

  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_DRAIN    = 2'd2;

  localparam logic [1:0] STAT_JOB     = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_DROPPED = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] job_id;
    logic [7:0]  job_priority;
    logic [15:0] job_length;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_id;
    logic [7:0]  out_priority;
    logic [15:0] out_length;
    logic [31:0] turnaround;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // one queue entry as kept in the slot memory
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] length;
    logic [31:0] entry_time;
  } slot_t;

  // strobes from the sequencer to the time accounting
  typedef struct packed {
    logic cfg_we;
    logic advance;
    logic pop;
  } acct_ctl_t;

endpackage

FILE: design/sjn_acct.sv
// time accounting: time step register, current time, completion total, turnaround
module sjn_acct (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sjn_pkg::acct_ctl_t    ctl_i,
  input  logic [7:0]            cfg_data_i,
  input  logic [15:0]           pop_length_i,
  input  logic [31:0]           pop_entry_i,
  output logic [31:0]           now_o,
  output logic [31:0]           turnaround_o
);

  logic [7:0]  time_step_q;
  logic [31:0] now_q;
  logic [31:0] total_q;
  logic [31:0] total_d;

  assign total_d      = total_q + {16'd0, pop_length_i};
  assign turnaround_o = total_d - pop_entry_i;
  assign now_o        = now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= sjn_pkg::TIME_STEP_RESET;
      now_q       <= '0;
      total_q     <= '0;
    end else begin
      if (ctl_i.cfg_we) begin
        time_step_q <= cfg_data_i;
      end
      if (ctl_i.advance) begin
        now_q <= now_q + {24'd0, time_step_q};
      end
      if (ctl_i.pop) begin
        total_q <= total_d;
      end
    end
  end

endmodule

FILE: design/shortest_job_next_queue.sv
// top level of the shortest-job-next queue: sequencer, slot memory and output register
//
// usage:
//   input channel (in_valid_i / in_stall_o / in_data_i) takes one transaction per
//   action: insert a job, dispatch the head job, or drain the whole queue.
//   output channel (out_valid_o / out_stall_i / out_data_o) delivers result
//   transactions: a dispatched or drained job, an empty-dispatch error, or a
//   dropped insert; last marks the final result of an input transaction.
//   cfg_we_i / cfg_data_i write the time step; write it only while idle.
// timing:
//   the block works on one transaction at a time; in_stall_o is high while busy.
//   insert holds in_stall_o longer the more queued jobs are longer than the new one;
//   every shifted entry costs one read and one write through the single slot
//   memory port pair. dispatch passes S_POP_RD and S_POP_OUT before out_valid_o
//   rises, and drain repeats both states for each job; S_POP_OUT waits while the
//   output register is held by out_stall_i.
// reset: queue empty, time and completion total zero, time step 20; the slot
//   memory itself is not cleared, only entries below the job count are read.
// stall: a result waits in the output register; the sequencer holds until the
//   register is free, so nothing is lost or repeated.
module shortest_job_next_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sjn_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sjn_pkg::out_item_t   out_data_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_data_i
);

  localparam int IdxW = sjn_pkg::IDX_W;
  localparam int CntW = sjn_pkg::CNT_W;
  localparam int SumW = sjn_pkg::CNT_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_POP_RD,
    S_POP_OUT,
    S_EMPTY,
    S_DROP
  } state_e;

  state_e                   state_q;
  logic [IdxW-1:0]          head_q;
  logic [CntW-1:0]          count_q;
  logic [CntW-1:0]          ins_idx_q;
  sjn_pkg::in_item_t        job_q;
  logic                     drain_q;
  logic                     out_valid_q;
  sjn_pkg::out_item_t       out_data_q;

  // slot memory, one read and one write port
  sjn_pkg::slot_t           mem_q [sjn_pkg::QUEUE_DEPTH];
  sjn_pkg::slot_t           rd_data_q;
  logic                     rd_en;
  logic [IdxW-1:0]          rd_addr;
  logic                     wr_en;
  logic [IdxW-1:0]          wr_addr;
  sjn_pkg::slot_t           wr_data;
  sjn_pkg::slot_t           new_slot;

  sjn_pkg::acct_ctl_t       acct_ctl;
  logic [31:0]              now;
  logic [31:0]              turnaround;

  logic                     in_accept;
  logic                     out_free;
  logic                     queue_full;

  // logical queue position to memory address, ring from head_q
  function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] head,
                                           input logic [CntW-1:0] pos);
    logic [SumW-1:0] sum;
    sum = SumW'(head) + SumW'(pos);
    if (sum >= SumW'(sjn_pkg::QUEUE_DEPTH)) begin
      sum = sum - SumW'(sjn_pkg::QUEUE_DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign queue_full = (count_q == CntW'(sjn_pkg::QUEUE_DEPTH));
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign new_slot = '{id: job_q.job_id, prio: job_q.job_priority,
                      length: job_q.job_length, entry_time: now};

  // memory port control from the sequencer state
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = head_q;
    wr_en    = 1'b0;
    wr_addr  = phys(head_q, ins_idx_q);
    wr_data  = new_slot;
    acct_ctl = '{cfg_we: cfg_we_i, advance: 1'b0, pop: 1'b0};
    case (state_q)
      S_IDLE: begin
        acct_ctl.advance = in_accept && (in_data_i.action == sjn_pkg::ACT_DISPATCH);
      end
      S_INS_RD: begin
        if (ins_idx_q == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = phys(head_q, ins_idx_q - CntW'(1));
        end
      end
      S_INS_CMP: begin
        // a longer entry moves up one place, else the new job lands here
        wr_en = 1'b1;
        if (rd_data_q.length > job_q.job_length) begin
          wr_data = rd_data_q;
        end
      end
      S_POP_RD: begin
        rd_en = 1'b1;
      end
      S_POP_OUT: begin
        acct_ctl.pop = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  sjn_acct u_acct (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (acct_ctl),
    .cfg_data_i   (cfg_data_i),
    .pop_length_i (rd_data_q.length),
    .pop_entry_i  (rd_data_q.entry_time),
    .now_o        (now),
    .turnaround_o (turnaround)
  );

  // sequencer, queue bookkeeping and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      ins_idx_q   <= '0;
      job_q       <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            job_q <= in_data_i;
            case (in_data_i.action)
              sjn_pkg::ACT_INSERT: begin
                ins_idx_q <= count_q;
                state_q   <= queue_full ? S_DROP : S_INS_RD;
              end
              sjn_pkg::ACT_DISPATCH: begin
                drain_q <= 1'b0;
                state_q <= (count_q == '0) ? S_EMPTY : S_POP_RD;
              end
              sjn_pkg::ACT_DRAIN: begin
                drain_q <= 1'b1;
                if (count_q != '0) begin
                  state_q <= S_POP_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_INS_RD: begin
          if (ins_idx_q == '0) begin
            count_q <= count_q + CntW'(1);
            state_q <= S_IDLE;
          end else begin
            state_q <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rd_data_q.length > job_q.job_length) begin
            ins_idx_q <= ins_idx_q - CntW'(1);
            state_q   <= S_INS_RD;
          end else begin
            count_q <= count_q + CntW'(1);
            state_q <= S_IDLE;
          end
        end
        S_POP_RD: begin
          state_q <= S_POP_OUT;
        end
        S_POP_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= '{out_id: rd_data_q.id, out_priority: rd_data_q.prio,
                             out_length: rd_data_q.length, turnaround: turnaround,
                             status: sjn_pkg::STAT_JOB,
                             last: !drain_q || (count_q == CntW'(1))};
            head_q  <= (head_q == IdxW'(sjn_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                    : head_q + IdxW'(1);
            count_q <= count_q - CntW'(1);
            state_q <= (!drain_q || (count_q == CntW'(1))) ? S_IDLE : S_POP_RD;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= '{out_id: '0, out_priority: '0, out_length: '0,
                             turnaround: '0, status: sjn_pkg::STAT_EMPTY, last: 1'b1};
            state_q     <= S_IDLE;
          end
        end
        S_DROP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= '{out_id: job_q.job_id, out_priority: job_q.job_priority,
                             out_length: job_q.job_length, turnaround: '0,
                             status: sjn_pkg::STAT_DROPPED, last: 1'b1};
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // job count never passes the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(sjn_pkg::QUEUE_DEPTH))
    else $error("job count above queue depth");

  // a popped job shrinks the queue by exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_OUT && out_free) |=> count_q == $past(count_q) - CntW'(1))
    else $error("pop did not decrement job count");

  // an insert into a full queue goes to the drop path and never writes memory
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.action == sjn_pkg::ACT_INSERT && queue_full)
      |=> (state_q == S_DROP && !wr_en))
    else $error("insert into full queue not dropped");

  // pops only run with jobs in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_RD || state_q == S_POP_OUT) |-> count_q != '0)
    else $error("pop on empty queue");

endmodule

FILE: tb/sv/sjn_scoreboard_pkg.sv
// scoreboard for the shortest-job-next queue: job order prediction and result checking
package sjn_scoreboard_pkg;
  import sjn_pkg::*;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] len;
    logic [31:0] entered;
  } queued_job_t;

  class sjn_scoreboard;
    queued_job_t jobs[QUEUE_DEPTH];
    int unsigned job_total;
    logic [31:0] completion_sum;
    logic [31:0] clock_now;
    logic [7:0]  time_step;
    out_item_t   pending_results[$];
    int unsigned errors;
    int unsigned inputs_seen;
    int unsigned results_seen;
    int unsigned jobs_out;
    int unsigned empty_dispatches;
    int unsigned dropped_inserts;

    function new();
      job_total      = 0;
      completion_sum = '0;
      clock_now      = '0;
      time_step      = TIME_STEP_RESET;
      errors         = 0;
    endfunction

    // head job leaves the queue and is charged to the completion sum
    function void retire_head(logic last_flag);
      out_item_t r;
      completion_sum = completion_sum + {16'd0, jobs[0].len};
      r = '{out_id: jobs[0].id, out_priority: jobs[0].prio, out_length: jobs[0].len,
            turnaround: completion_sum - jobs[0].entered, status: STAT_JOB,
            last: last_flag};
      pending_results.push_back(r);
      for (int i = 1; i < job_total; i++) jobs[i - 1] = jobs[i];
      job_total--;
    endfunction

    function void note_input(in_item_t it);
      int unsigned pos;
      out_item_t r;
      inputs_seen++;
      case (it.action)
        ACT_INSERT: begin
          if (job_total >= QUEUE_DEPTH) begin
            r = '{out_id: it.job_id, out_priority: it.job_priority,
                  out_length: it.job_length, turnaround: '0, status: STAT_DROPPED,
                  last: 1'b1};
            pending_results.push_back(r);
          end else begin
            pos = 0;
            while (pos < job_total && jobs[pos].len <= it.job_length) pos++;
            for (int i = job_total; i > pos; i--) jobs[i] = jobs[i - 1];
            jobs[pos] = '{id: it.job_id, prio: it.job_priority, len: it.job_length,
                          entered: clock_now};
            job_total++;
          end
        end
        ACT_DISPATCH: begin
          clock_now = clock_now + {24'd0, time_step};
          if (job_total == 0) begin
            r = '{out_id: '0, out_priority: '0, out_length: '0, turnaround: '0,
                  status: STAT_EMPTY, last: 1'b1};
            pending_results.push_back(r);
          end else begin
            retire_head(1'b1);
          end
        end
        ACT_DRAIN: begin
          while (job_total > 0) retire_head(job_total == 1);
        end
        default: ;
      endcase
    endfunction

    function void report(longint unsigned stamp, string field, logic [31:0] want,
                         logic [31:0] got);
      $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h", stamp, field, want, got);
      errors++;
    endfunction

    function void check_result(out_item_t got, longint unsigned stamp);
      out_item_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0d ns: unexpected result, expected none, actual 0x%0h", stamp, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      case (want.status)
        STAT_JOB:   jobs_out++;
        STAT_EMPTY: empty_dispatches++;
        default:    dropped_inserts++;
      endcase
      if (got.out_id !== want.out_id) report(stamp, "out_id", want.out_id, got.out_id);
      if (got.out_priority !== want.out_priority)
        report(stamp, "out_priority", want.out_priority, got.out_priority);
      if (got.out_length !== want.out_length)
        report(stamp, "out_length", want.out_length, got.out_length);
      if (got.turnaround !== want.turnaround)
        report(stamp, "turnaround", want.turnaround, got.turnaround);
      if (got.status !== want.status) report(stamp, "status", want.status, got.status);
      if (got.last !== want.last) report(stamp, "last", want.last, got.last);
    endfunction
  endclass

endpackage

FILE: tb/sv/tb_shortest_job_next_queue.sv
// testbench top of the shortest-job-next queue: stimulus, stall control and checking
module tb_shortest_job_next_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import sjn_pkg::*;
  import sjn_scoreboard_pkg::*;

  // action code that the block ignores
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // covers the longest insert, which shifts all 15 queued jobs and gives no result
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 400;
  localparam int ITEMS_PER_PHASE = 42;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_we_i    = 1'b0;
  logic [7:0] cfg_data_i = '0;

  sjn_scoreboard sb = new();

  // idle and stall percentages for the current phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // receiver hold-off: requested by the stimulus, counted down by the receiver
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  shortest_job_next_queue uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit, well above the slowest legal run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               sb.pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: every accepted transaction on either channel and every register write
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.time_step = cfg_data_i;
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o, $time);
    end
  end

  function automatic in_item_t job(logic [1:0] act, logic [15:0] id, logic [7:0] prio,
                                   logic [15:0] len);
    in_item_t it;
    it = '{action: act, job_id: id, job_priority: prio, job_length: len};
    return it;
  endfunction

  // random insert; mostly short lengths so that equal keys are common
  function automatic in_item_t random_insert();
    logic [15:0] len;
    len = ($urandom_range(9) < 7) ? 16'($urandom_range(15)) : 16'($urandom);
    return job(ACT_INSERT, 16'($urandom), 8'($urandom), len);
  endfunction

  // random transaction: inserts dominate, dispatch and drain keep the queue moving
  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned pick;
    it = random_insert();
    pick = $urandom_range(99);
    if (pick < 3) it.action = ACT_UNUSED;
    else if (pick < 13) it.action = ACT_DRAIN;
    else if (pick < 43) it.action = ACT_DISPATCH;
    return it;
  endfunction

  // offer one transaction, with random idle cycles ahead of it; valid stays high after
  // acceptance so that back-to-back transactions need no extra assignment
  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // sender pauses until every expected result is back and the block has settled
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_time_step(logic [7:0] value);
    wait_quiet();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic random_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned sent;
    in_item_t it;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < ITEMS_PER_PHASE) begin
      if ($urandom_range(11) == 0) begin
        // insert burst, often enough to hit the full queue
        repeat ($urandom_range(QUEUE_DEPTH + 2, 4)) begin
          send(random_insert());
          sent++;
        end
      end else begin
        it = random_item();
        send(it);
        if (it.action != ACT_UNUSED) sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue cases, ignored action, field extremes, equal keys
    send(job(ACT_DISPATCH, 16'h1234, 8'h56, 16'h789a));
    send(job(ACT_DRAIN, 16'h0000, 8'h00, 16'h0000));
    send(job(ACT_UNUSED, 16'hffff, 8'hff, 16'hffff));
    send(job(ACT_INSERT, 16'hffff, 8'hff, 16'hffff));
    send(job(ACT_INSERT, 16'h0000, 8'h00, 16'h0000));
    send(job(ACT_INSERT, 16'h0001, 8'h11, 16'd100));
    send(job(ACT_INSERT, 16'h0002, 8'h22, 16'd100));
    send(job(ACT_INSERT, 16'h0003, 8'h33, 16'd50));
    send(job(ACT_INSERT, 16'h0004, 8'h44, 16'hffff));
    send(job(ACT_DISPATCH, 16'h0000, 8'h00, 16'h0000));
    send(job(ACT_DRAIN, 16'h0000, 8'h00, 16'h0000));
    send(job(ACT_DRAIN, 16'h0000, 8'h00, 16'h0000));

    // full queue under back-pressure, with the largest step
    write_time_step(8'hff);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send(job(ACT_INSERT, 16'(16'h0100 + i), 8'(i), 16'((QUEUE_DEPTH - i) * 1000)));
    hold_request = HOLD_CYCLES;
    send(job(ACT_INSERT, 16'hbeef, 8'ha5, 16'd1));
    send(job(ACT_DISPATCH, 16'h0000, 8'h00, 16'h0000));
    send(job(ACT_INSERT, 16'h0200, 8'h5a, 16'd7));
    send(job(ACT_DRAIN, 16'h0000, 8'h00, 16'h0000));
    send(job(ACT_DISPATCH, 16'h0000, 8'h00, 16'h0000));

    // random phases: sender idles rarely, then the receiver does, then nobody
    write_time_step(8'h00);
    random_phase(8, 69);
    write_time_step(8'($urandom_range(254, 1)));
    random_phase(69, 8);
    write_time_step(8'($urandom));
    random_phase(0, 0);

    wait_quiet();
    if (sb.pending_results.size() != 0) begin
      $display("%0d results never arrived", sb.pending_results.size());
      sb.errors++;
    end
    $display("run covered %0d input transactions and %0d result transactions:",
             sb.inputs_seen, sb.results_seen);
    $display("  %0d jobs reported, %0d empty dispatches, %0d dropped inserts, %0d errors",
             sb.jobs_out, sb.empty_dispatches, sb.dropped_inserts, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
